// File: sv/temb_pkg.sv
// ----------------------------------------------------------------------------
// temb_pkg
// Shared types, constants and helpers for the theta-method ball step core.
// ----------------------------------------------------------------------------
package temb_pkg;

   localparam int WORD_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int TIME_WIDTH     = 48;
   localparam int ALPHA_WIDTH    = 17;
   localparam int ITER_WIDTH     = 8;
   localparam int ITER_LIMIT_DEF = 255;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 128;
   localparam int RSP_DATA_WIDTH = 192;

   localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = 17'h10000;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic signed [WORD_WIDTH+2:0] wide_type;

   localparam word_type WMAX = 32'sh7FFF_FFFF;
   localparam word_type WMIN = 32'sh8000_0000;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_ALPHA    = 3'd0,
      CSR_DT       = 3'd1,
      CSR_TOL      = 3'd2,
      CSR_MAX_ITER = 3'd3,
      CSR_MAGNUS   = 3'd4,
      CSR_DRAG     = 3'd5,
      CSR_GRAVITY  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WB,
      ST_SQRT,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      U_TOL,
      U_VX2,
      U_VY2,
      U_FR,
      U_T0,
      U_T1,
      U_T2,
      U_T3,
      U_SA,
      U_SB,
      U_RSQ
   } uop_type;

   typedef enum logic [1:0] {
      C_INIT,
      C_UPD,
      C_RES
   } ctx_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] a;
      logic [WORD_WIDTH-1:0] b;
      logic                  neg;
   } mul_req_type;

   function automatic logic [WORD_WIDTH-1:0] mag(input word_type v);
      mag = v[WORD_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic wide_type sx(input word_type v);
      sx = {{3{v[WORD_WIDTH-1]}}, v};
   endfunction

   function automatic word_type sat(input wide_type v);
      if (v > sx(WMAX)) begin
         sat = WMAX;
      end else if (v < sx(WMIN)) begin
         sat = WMIN;
      end else begin
         sat = v[WORD_WIDTH-1:0];
      end
   endfunction

endpackage

// File: sv/temb_mul.sv
// ----------------------------------------------------------------------------
// temb_mul
// Shared magnitude multiplier with registered product and Q16.16 rounding.
// ----------------------------------------------------------------------------
module temb_mul (
   input  logic                                       clock,
   input  temb_pkg::mul_req_type                      req,
   output logic [2*temb_pkg::WORD_WIDTH-1:0]          prod,
   output temb_pkg::word_type                         fix
);
   import temb_pkg::*;

   logic [2*WORD_WIDTH-1:0] prod_ff;
   logic                    neg_ff;
   logic [2*WORD_WIDTH:0]   rnd;
   logic [2*WORD_WIDTH-FRAC_BITS:0] hi;

   always_ff @(posedge clock) begin
      prod_ff <= req.a * req.b;
      neg_ff  <= req.neg;
   end

   assign rnd  = {1'b0, prod_ff} + (65'd1 << (FRAC_BITS - 1));
   assign hi   = rnd[2*WORD_WIDTH:FRAC_BITS];
   assign prod = prod_ff;

   always_comb begin
      if (hi > 49'(WMAX)) begin
         fix = neg_ff ? WMIN : WMAX;
      end else begin
         fix = neg_ff ? -$signed(hi[WORD_WIDTH-1:0]) : $signed(hi[WORD_WIDTH-1:0]);
      end
   end

endmodule

// File: sv/temb_sqrt.sv
// ----------------------------------------------------------------------------
// temb_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module temb_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [2*temb_pkg::WORD_WIDTH-1:0]   radicand,
   output logic                                done,
   output logic [temb_pkg::WORD_WIDTH-1:0]     root
);
   import temb_pkg::*;

   logic [2*WORD_WIDTH-1:0] rad_ff, rad_in;
   logic [WORD_WIDTH+2:0]   rem_ff, rem_in, rem_sh, trial;
   logic [WORD_WIDTH-1:0]   root_ff, root_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic                    run_ff, run_in, done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign rem_sh = {rem_ff[WORD_WIDTH:0], rad_ff[2*WORD_WIDTH-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'(WORD_WIDTH - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[WORD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[WORD_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: sv/theta_euler_magnus_ball_step_core.sv
// ----------------------------------------------------------------------------
// theta_euler_magnus_ball_step_core
// Theta-method Euler stepper for a spinning ball with drag and gravity.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) goes straight to ST_DONE and its result. A step beat
// (tuser 1) runs on one shared 32x32 multiplier and a bit-serial square root:
// a setup pass, then fixed-point iterations (two derivative evaluations, each
// with a square root, plus the update and residual passes), then the result.
// The block takes no new beat until the previous result has been issued to
// the output register.
module theta_euler_magnus_ball_step_core #(
   parameter int ITER_LIMIT = temb_pkg::ITER_LIMIT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // pos_x_in, pos_y_in, vel_x_in, vel_y_in
   input  logic [temb_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // operation
   input  logic [0:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // time_out, pos_x_out, pos_y_out, vel_x_out, vel_y_out, iterations_used,
   // converged, zero fill
   output logic [temb_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   input  logic                                   csr_we,
   input  logic [temb_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  logic [temb_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import temb_pkg::*;

   // config
   logic [ALPHA_WIDTH-1:0] alpha_ff;
   logic [WORD_WIDTH-1:0]  dt_ff, tol_ff, drag_ff;
   logic [ITER_WIDTH-1:0]  max_iter_ff;
   word_type               magnus_ff, gravity_ff;

   state_type state_ff, state_in;
   uop_type   uop_ff, uop_in;
   ctx_type   ctx_ff, ctx_in;

   word_type y_ff [4], y_in [4];
   word_type yo_ff [4], yo_in [4];
   word_type f_ff [4], f_in [4];
   word_type dee_ff [4], dee_in [4];
   word_type t_ff [3], t_in [3];
   word_type fr_ff, fr_in, u_ff, u_in, r_ff, r_in, sp_ff, sp_in;
   logic [TIME_WIDTH-1:0]   time_ff, time_in;
   logic [2*WORD_WIDTH-1:0] tol2_ff, tol2_in, acc_ff, acc_in;
   logic [2*WORD_WIDTH:0]   ss_ff, ss_in;
   logic [ITER_WIDTH-1:0]   used_ff, used_in, lim_ff, lim_in;
   logic                    conv_ff, conv_in;
   logic [1:0]              idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   mul_req_type             mreq;
   logic [2*WORD_WIDTH-1:0] prod;
   word_type                fix;
   logic                    sq_start, sq_done;
   logic [WORD_WIDTH-1:0]   sq_root;
   logic [ALPHA_WIDTH-1:0]  coef;
   logic [ALPHA_WIDTH-1:0]  alpha_wr;
   logic                    conv_now;

   temb_mul u_mul (
      .clock (clock),
      .req   (mreq),
      .prod  (prod),
      .fix   (fix)
   );

   temb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff + prod),
      .done     (sq_done),
      .root     (sq_root)
   );

   // config port
   assign alpha_wr = csr_wdata[ALPHA_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= ALPHA_WIDTH'(32768);
         dt_ff       <= 32'd655;
         tol_ff      <= 32'd66;
         max_iter_ff <= 8'd32;
         magnus_ff   <= '0;
         drag_ff     <= '0;
         gravity_ff  <= 32'sd642252;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ALPHA:    alpha_ff    <= (alpha_wr > ALPHA_ONE) ? ALPHA_ONE : alpha_wr;
            CSR_DT:       dt_ff       <= csr_wdata;
            CSR_TOL:      tol_ff      <= csr_wdata;
            CSR_MAX_ITER: max_iter_ff <= csr_wdata[ITER_WIDTH-1:0];
            CSR_MAGNUS:   magnus_ff   <= $signed(csr_wdata);
            CSR_DRAG:     drag_ff     <= csr_wdata;
            CSR_GRAVITY:  gravity_ff  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         uop_ff       <= U_TOL;
         ctx_ff       <= C_INIT;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
         for (int i = 0; i < 4; i++) y_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         uop_ff       <= uop_in;
         ctx_ff       <= ctx_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         for (int i = 0; i < 4; i++) y_ff[i] <= y_in[i];
      end
      for (int i = 0; i < 4; i++) begin
         yo_ff[i]  <= yo_in[i];
         f_ff[i]   <= f_in[i];
         dee_ff[i] <= dee_in[i];
      end
      for (int i = 0; i < 3; i++) t_ff[i] <= t_in[i];
      fr_ff       <= fr_in;
      u_ff        <= u_in;
      r_ff        <= r_in;
      sp_ff       <= sp_in;
      tol2_ff     <= tol2_in;
      acc_ff      <= acc_in;
      ss_ff       <= ss_in;
      used_ff     <= used_in;
      lim_ff      <= lim_in;
      conv_ff     <= conv_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign coef = (ctx_ff == C_INIT) ? alpha_ff : (ALPHA_ONE - alpha_ff);

   // multiplier operand select
   always_comb begin
      mreq = '{a: '0, b: '0, neg: 1'b0};
      unique case (uop_ff)
         U_TOL: mreq = '{a: tol_ff, b: tol_ff, neg: 1'b0};
         U_VX2: mreq = '{a: mag(y_ff[2]), b: mag(y_ff[2]), neg: 1'b0};
         U_VY2: mreq = '{a: mag(y_ff[3]), b: mag(y_ff[3]), neg: 1'b0};
         U_FR:  mreq = '{a: drag_ff, b: sp_ff, neg: 1'b0};
         U_T0:  mreq = '{a: mag(magnus_ff), b: mag(y_ff[3]),
                         neg: magnus_ff[WORD_WIDTH-1] ^ y_ff[3][WORD_WIDTH-1]};
         U_T1:  mreq = '{a: mag(fr_ff), b: mag(y_ff[2]),
                         neg: fr_ff[WORD_WIDTH-1] ^ y_ff[2][WORD_WIDTH-1]};
         U_T2:  mreq = '{a: mag(magnus_ff), b: mag(y_ff[2]),
                         neg: magnus_ff[WORD_WIDTH-1] ^ y_ff[2][WORD_WIDTH-1]};
         U_T3:  mreq = '{a: mag(fr_ff), b: mag(y_ff[3]),
                         neg: fr_ff[WORD_WIDTH-1] ^ y_ff[3][WORD_WIDTH-1]};
         U_SA:  mreq = '{a: WORD_WIDTH'(coef), b: mag(f_ff[idx_ff]),
                         neg: f_ff[idx_ff][WORD_WIDTH-1]};
         U_SB:  mreq = '{a: mag(u_ff), b: dt_ff, neg: u_ff[WORD_WIDTH-1]};
         U_RSQ: mreq = '{a: mag(r_ff), b: mag(r_ff), neg: 1'b0};
         default: ;
      endcase
   end

   assign conv_now = ss_ff <= {1'b0, tol2_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      uop_in       = uop_ff;
      ctx_in       = ctx_ff;
      y_in         = y_ff;
      yo_in        = yo_ff;
      f_in         = f_ff;
      dee_in       = dee_ff;
      t_in         = t_ff;
      fr_in        = fr_ff;
      u_in         = u_ff;
      r_in         = r_ff;
      sp_in        = sp_ff;
      time_in      = time_ff;
      tol2_in      = tol2_ff;
      acc_in       = acc_ff;
      ss_in        = ss_ff;
      used_in      = used_ff;
      lim_in       = lim_ff;
      conv_in      = conv_ff;
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      sq_start     = 1'b0;
      req_tready   = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               used_in = '0;
               conv_in = 1'b0;
               if (req_tuser[0] == 1'b0) begin
                  y_in[0]  = $signed(req_tdata[31:0]);
                  y_in[1]  = $signed(req_tdata[63:32]);
                  y_in[2]  = $signed(req_tdata[95:64]);
                  y_in[3]  = $signed(req_tdata[127:96]);
                  time_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  yo_in    = y_ff;
                  lim_in   = (32'(max_iter_ff) < ITER_LIMIT) ? max_iter_ff
                                                             : ITER_WIDTH'(ITER_LIMIT);
                  uop_in   = U_TOL;
                  ctx_in   = C_INIT;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: state_in = ST_WB;
         ST_WB: begin
            state_in = ST_MUL;
            unique case (uop_ff)
               U_TOL: begin
                  tol2_in = prod;
                  uop_in  = U_VX2;
               end
               U_VX2: begin
                  acc_in = prod;
                  uop_in = U_VY2;
               end
               U_VY2: begin
                  sq_start = 1'b1;
                  state_in = ST_SQRT;
               end
               U_FR: begin
                  fr_in  = fix;
                  uop_in = U_T0;
               end
               U_T0: begin
                  t_in[0] = fix;
                  uop_in  = U_T1;
               end
               U_T1: begin
                  t_in[1] = fix;
                  uop_in  = U_T2;
               end
               U_T2: begin
                  t_in[2] = fix;
                  uop_in  = U_T3;
               end
               U_T3: begin
                  f_in[0] = y_ff[2];
                  f_in[1] = y_ff[3];
                  f_in[2] = sat(-sx(t_ff[0]) - sx(t_ff[1]));
                  f_in[3] = sat(sx(t_ff[2]) - sx(gravity_ff) - sx(fix));
                  idx_in  = '0;
                  uop_in  = U_SA;
               end
               U_SA: begin
                  u_in   = fix;
                  uop_in = U_SB;
               end
               U_SB: begin
                  idx_in = idx_ff + 1'b1;
                  uop_in = U_SA;
                  unique case (ctx_ff)
                     C_INIT: dee_in[idx_ff] = fix;
                     C_UPD:  y_in[idx_ff] = sat(sx(yo_ff[idx_ff]) + sx(dee_ff[idx_ff])
                                                + sx(fix));
                     default: begin
                        r_in   = sat(sx(y_ff[idx_ff]) - sx(yo_ff[idx_ff])
                                     - sx(dee_ff[idx_ff]) - sx(fix));
                        idx_in = idx_ff;
                        uop_in = U_RSQ;
                     end
                  endcase
                  if (ctx_ff != C_RES && idx_ff == 2'd3) begin
                     uop_in = U_VX2;
                     if (ctx_ff == C_INIT) begin
                        ctx_in = C_UPD;
                        if (lim_ff == '0) begin
                           time_in  = time_ff + TIME_WIDTH'(dt_ff);
                           state_in = ST_DONE;
                        end
                     end else begin
                        ctx_in = C_RES;
                        ss_in  = '0;
                     end
                  end
               end
               U_RSQ: begin
                  ss_in  = ss_ff + {1'b0, prod};
                  idx_in = idx_ff + 1'b1;
                  uop_in = U_SA;
                  if (idx_ff == 2'd3) begin
                     state_in = ST_CHECK;
                  end
               end
               default: ;
            endcase
         end
         ST_SQRT: begin
            if (sq_done) begin
               sp_in    = sq_root[WORD_WIDTH-1] ? WMAX : $signed(sq_root);
               uop_in   = U_FR;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            conv_in = conv_now;
            used_in = used_ff + 1'b1;
            if (!conv_now && (used_ff + 1'b1) < lim_ff) begin
               ctx_in   = C_UPD;
               uop_in   = U_VX2;
               state_in = ST_MUL;
            end else begin
               time_in  = time_ff + TIME_WIDTH'(dt_ff);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {7'd0, conv_ff, used_ff, y_ff[3], y_ff[2], y_ff[1],
                               y_ff[0], time_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_check_under_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (used_ff < lim_ff))
      else $error("iteration check past limit");

   a_conv_needs_iter: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[184]) |-> (rsp_tdata[183:176] != '0))
      else $error("converged without iterations");

   a_sqrt_done_state: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_SQRT))
      else $error("square root finished outside its wait state");

   a_sqrt_start: assert property (@(posedge clock) disable iff (reset)
      sq_start |=> (state_ff == ST_SQRT))
      else $error("square root started without waiting");

endmodule

// File: tb/sv/theta_euler_magnus_ball_step_core_test.sv
// ----------------------------------------------------------------------------
// theta_euler_magnus_ball_step_core_test
// Self-checking bench: loads and steps ball states through several register
// settings, predicts every result in fixed point and compares each rsp beat.
// ----------------------------------------------------------------------------
module theta_euler_magnus_ball_step_core_test;
   import temb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_UNUSED = 3'd7;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam int ITEM_GOAL = 1900;

   typedef struct {
      logic [47:0] elapsed;
      logic [31:0] px, py, vx, vy;
      logic [7:0]  iters;
      logic        conv;
   } ball_result_type;

   typedef struct {
      logic        op;
      logic [31:0] px, py, vx, vy;
      logic        typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   ball_result_type pending_results[$];
   int mismatches = 0;
   int items_sent = 0;
   bit calm = 1'b0;

   // predictor copy of registers and state
   longint m_alpha, m_dt, m_tol, m_maxit, m_magnus, m_drag, m_grav;
   longint m_pos_x, m_pos_y, m_vel_x, m_vel_y;
   logic [47:0] m_time;

   always #10 clock = ~clock;

   theta_euler_magnus_ball_step_core dut (.*);

   function automatic longint clip(input longint v);
      return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      logic [127:0] p;
      logic [63:0] ma, mb;
      logic neg;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = {64'b0, ma} * {64'b0, mb};
      p = (p + 128'd32768) >> 16;
      if (p > 128'h7FFF_FFFF) return neg ? QMIN : QMAX;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic logic [127:0] sq(input longint v);
      logic [63:0] m;
      m = v < 0 ? -v : v;
      return {64'b0, m} * {64'b0, m};
   endfunction

   function automatic void ball_slope(input longint s[4], output longint f[4]);
      logic [127:0] n;
      logic [63:0] r, c;
      longint fr;
      n = sq(s[2]) + sq(s[3]);
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'b0, c} * {64'b0, c} <= n) r = c;
      end
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      fr = qmul(m_drag, longint'(r));
      f[0] = s[2];
      f[1] = s[3];
      f[2] = clip(-qmul(m_magnus, s[3]) - qmul(fr, s[2]));
      f[3] = clip(qmul(m_magnus, s[2]) - m_grav - qmul(fr, s[3]));
   endfunction

   function automatic void model_csr(input logic [2:0] idx, input logic [31:0] v);
      case (idx)
         CSR_ALPHA: begin
            m_alpha = v[16:0] > 17'h10000 ? 65536 : longint'(v[16:0]);
         end
         CSR_DT: m_dt = longint'(v);
         CSR_TOL: m_tol = longint'(v);
         CSR_MAX_ITER: m_maxit = longint'(v[7:0]);
         CSR_MAGNUS: m_magnus = longint'(signed'(v));
         CSR_DRAG: m_drag = longint'(v);
         CSR_GRAVITY: m_grav = longint'(signed'(v));
         default: ;
      endcase
   endfunction

   function automatic ball_result_type advance_ball(input logic op, input logic [31:0] ix,
         input logic [31:0] iy, input logic [31:0] jx, input logic [31:0] jy);
      ball_result_type res;
      longint yo[4], y[4], f[4], dee[4], rr[4];
      longint lim, used;
      logic [127:0] ss, tol2;
      logic conv;
      used = 0;
      conv = 1'b0;
      if (op == OP_LOAD) begin
         m_pos_x = longint'(signed'(ix));
         m_pos_y = longint'(signed'(iy));
         m_vel_x = longint'(signed'(jx));
         m_vel_y = longint'(signed'(jy));
         m_time = '0;
      end else begin
         lim = m_maxit < ITER_LIMIT_DEF ? m_maxit : ITER_LIMIT_DEF;
         tol2 = {64'b0, m_tol} * {64'b0, m_tol};
         yo = '{m_pos_x, m_pos_y, m_vel_x, m_vel_y};
         y = yo;
         ball_slope(yo, f);
         for (int i = 0; i < 4; i++) dee[i] = qmul(qmul(m_alpha, f[i]), m_dt);
         while (!conv && used < lim) begin
            ball_slope(y, f);
            for (int i = 0; i < 4; i++)
               y[i] = clip(yo[i] + dee[i] + qmul(qmul(65536 - m_alpha, f[i]), m_dt));
            ball_slope(y, f);
            ss = '0;
            for (int i = 0; i < 4; i++) begin
               rr[i] = clip(y[i] - yo[i] - dee[i]
                            - qmul(qmul(65536 - m_alpha, f[i]), m_dt));
               ss = ss + sq(rr[i]);
            end
            conv = ss <= tol2;
            used++;
         end
         m_pos_x = y[0];
         m_pos_y = y[1];
         m_vel_x = y[2];
         m_vel_y = y[3];
         m_time = m_time + m_dt[47:0];
      end
      res.elapsed = m_time;
      res.px = m_pos_x[31:0];
      res.py = m_pos_y[31:0];
      res.vx = m_vel_x[31:0];
      res.vy = m_vel_y[31:0];
      res.iters = used[7:0];
      res.conv = conv;
      return res;
   endfunction

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: %s got %h want %h", $realtime, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
   end

   always @(posedge clock) begin
      ball_result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report("unexpected beat", rsp_tdata[63:0], '0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_tdata[47:0] !== w.elapsed) report("time_out", rsp_tdata[47:0], w.elapsed);
            if (rsp_tdata[79:48] !== w.px) report("pos_x_out", rsp_tdata[79:48], w.px);
            if (rsp_tdata[111:80] !== w.py) report("pos_y_out", rsp_tdata[111:80], w.py);
            if (rsp_tdata[143:112] !== w.vx) report("vel_x_out", rsp_tdata[143:112], w.vx);
            if (rsp_tdata[175:144] !== w.vy) report("vel_y_out", rsp_tdata[175:144], w.vy);
            if (rsp_tdata[183:176] !== w.iters)
               report("iterations_used", rsp_tdata[183:176], w.iters);
            if (rsp_tdata[184] !== w.conv) report("converged", rsp_tdata[184], w.conv);
         end
      end
   end

   task automatic send_beat(input logic op, input logic [31:0] ix, input logic [31:0] iy,
         input logic [31:0] jx, input logic [31:0] jy, input bit typed);
      ball_result_type exp_r;
      if (!calm && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {jy, jx, iy, ix};
      do @(posedge clock); while (!req_tready);
      exp_r = advance_ball(op, ix, iy, jx, jy);
      if (typed) begin
         // a load result reads straight back
         exp_r = '{48'd0, ix, iy, jx, jy, 8'd0, 1'b0};
      end
      pending_results.push_back(exp_r);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      model_csr(idx, v);
   endtask

   task automatic csr_set(input logic [31:0] a, input logic [31:0] dt, input logic [31:0] tol,
         input logic [31:0] it, input logic [31:0] mg, input logic [31:0] dr,
         input logic [31:0] gr);
      csr_write(CSR_ALPHA, a);
      csr_write(CSR_DT, dt);
      csr_write(CSR_TOL, tol);
      csr_write(CSR_MAX_ITER, it);
      csr_write(CSR_MAGNUS, mg);
      csr_write(CSR_DRAG, dr);
      csr_write(CSR_GRAVITY, gr);
      csr_write(CSR_UNUSED, $urandom());
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_word();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(0, 400000) - 200000;
         2: return $urandom_range(0, 4000) - 2000;
         default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   stim_row_type directed[] = '{
      '{OP_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1},
      '{OP_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{OP_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1},
      '{OP_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{OP_LOAD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1},
      '{OP_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
      '{OP_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{OP_LOAD, 32'h0001_0000, 32'h000A_0000, 32'h0005_0000, 32'h0014_0000, 1'b1},
      '{OP_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{OP_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{OP_LOAD, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001, 1'b1},
      '{OP_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}
   };

   initial begin
      int phase;
      int n;
      logic [31:0] a, it, tol;
      model_csr(CSR_ALPHA, 32'd32768);
      model_csr(CSR_DT, 32'd655);
      model_csr(CSR_TOL, 32'd66);
      model_csr(CSR_MAX_ITER, 32'd32);
      model_csr(CSR_MAGNUS, 32'd0);
      model_csr(CSR_DRAG, 32'd0);
      model_csr(CSR_GRAVITY, 32'd642252);
      m_pos_x = 0; m_pos_y = 0; m_vel_x = 0; m_vel_y = 0; m_time = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_beat(directed[i].op, directed[i].px, directed[i].py, directed[i].vx,
                   directed[i].vy, directed[i].typed);
      drain();

      // alpha above one saturates; explicit step converges at once, max limits
      csr_set(32'h0001_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000);
      send_beat(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_beat(OP_STEP, '0, '0, '0, '0, 1'b0);
      send_beat(OP_STEP, '0, '0, '0, '0, 1'b0);
      drain();
      // zero iteration limit: state held, time still moves
      csr_set(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0,
              32'h7FFF_FFFF);
      send_beat(OP_STEP, '0, '0, '0, '0, 1'b0);
      send_beat(OP_STEP, '0, '0, '0, '0, 1'b0);
      drain();
      csr_write(CSR_MAX_ITER, 32'hFF);
      csr_we <= 1'b0;
      send_beat(OP_STEP, '0, '0, '0, '0, 1'b0);
      send_beat(OP_LOAD, 32'h1234_5678, 32'hEDCB_A988, 32'h0003_0000, 32'hFFFD_0000, 1'b0);
      send_beat(OP_STEP, '0, '0, '0, '0, 1'b0);
      drain();

      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         calm = (phase == 4);
         case ($urandom_range(3))
            0: a = 32'd0;
            1: a = 32'd65536;
            default: a = $urandom();
         endcase
         tol = $urandom_range(3) == 0 ? $urandom() : $urandom_range(0, 200);
         it = $urandom_range(9) == 0 ? 32'hFF : $urandom_range(0, 4);
         if (it == 32'hFF) tol = 32'hFFFF_FFFF;
         csr_set(a, $urandom_range(4) == 0 ? $urandom() : $urandom_range(0, 3000), tol, it,
                 rnd_word(), $urandom_range(3) == 0 ? $urandom() : $urandom_range(0, 3000),
                 rnd_word());
         n = 0;
         while (n < 60) begin
            if ($urandom_range(4) == 0) begin
               send_beat(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(),
                         $urandom(), 1'b0);
               n++;
            end else begin
               send_beat(OP_LOAD, rnd_word(), rnd_word(), rnd_word(), rnd_word(), 1'b0);
               n++;
               repeat ($urandom_range(1, 6)) begin
                  send_beat(OP_STEP, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
                  n++;
               end
            end
         end
         drain();
         phase++;
      end
      calm = 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
sv/temb_pkg.sv
sv/temb_mul.sv
sv/temb_sqrt.sv
sv/theta_euler_magnus_ball_step_core.sv
tb/sv/theta_euler_magnus_ball_step_core_test.sv
